// ===== sv/alu8_pkg.sv =====
package alu8_pkg;

  localparam int OP_W = 5;
  localparam int BYTE_W = 8;
  localparam int WIDE_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 5'd0,
    OP_ADC      = 5'd1,
    OP_SUB      = 5'd2,
    OP_SBB      = 5'd3,
    OP_AND      = 5'd4,
    OP_XOR      = 5'd5,
    OP_OR       = 5'd6,
    OP_CMP      = 5'd7,
    OP_INR      = 5'd8,
    OP_DCR      = 5'd9,
    OP_DAA      = 5'd10,
    OP_RLC      = 5'd11,
    OP_RRC      = 5'd12,
    OP_RAL      = 5'd13,
    OP_RAR      = 5'd14,
    OP_CMA      = 5'd15,
    OP_CMC      = 5'd16,
    OP_STC      = 5'd17,
    OP_DAD      = 5'd18,
    OP_LOAD_A   = 5'd19,
    OP_LOAD_PSW = 5'd20,
    OP_READ     = 5'd21
  } op_t;

  typedef struct packed {
    logic s;
    logic z;
    logic h;
    logic p;
    logic c;
  } flags_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] operand;
    logic              target_is_acc;
    logic [WIDE_W-1:0] wide_left;
    logic [WIDE_W-1:0] wide_right;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] acc_out;
    logic [WIDE_W-1:0] value_out;
    logic [BYTE_W-1:0] flag_byte;
  } res_item_t;

  // Architectural state handed from the state registers to the datapath and back.
  typedef struct packed {
    logic [BYTE_W-1:0] acc;
    flags_t            flags;
  } arch_state_t;

  function automatic logic [BYTE_W-1:0] pack_flags(flags_t f);
    pack_flags = {f.s, f.z, 1'b0, f.h, 1'b0, f.p, 1'b1, f.c};
  endfunction

endpackage

// ===== sv/alu8_in_if.sv =====
interface alu8_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic [7:0]  operand;
  logic        target_is_acc;
  logic [15:0] wide_left;
  logic [15:0] wide_right;

  modport source (output valid, op, operand, target_is_acc, wide_left, wide_right,
                  input ready);
  modport sink (input valid, op, operand, target_is_acc, wide_left, wide_right,
                output ready);
endinterface

// ===== sv/alu8_out_if.sv =====
interface alu8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic [15:0] value_out;
  logic [7:0]  flag_byte;

  modport source (output valid, acc_out, value_out, flag_byte, input ready);
  modport sink (input valid, acc_out, value_out, flag_byte, output ready);
endinterface

// ===== sv/alu8_in_stage.sv =====
module alu8_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  alu8_in_if.sink           in_ch,
  input  logic              advance,
  output logic              item_vld,
  output alu8_pkg::in_item_t item
);
  import alu8_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;
  logic     take;

  // Refill in the same cycle the held beat moves on.
  assign in_ch.ready = !vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.op            <= op_t'(in_ch.op);
      item_r.operand       <= in_ch.operand;
      item_r.target_is_acc <= in_ch.target_is_acc;
      item_r.wide_left     <= in_ch.wide_left;
      item_r.wide_right    <= in_ch.wide_right;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;
endmodule

// ===== sv/alu8_exec.sv =====
module alu8_exec (
  input  alu8_pkg::in_item_t    item,
  input  alu8_pkg::arch_state_t cur,
  output alu8_pkg::arch_state_t nxt,
  output logic [15:0]           value
);
  import alu8_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [7:0]  logic_r;
  logic [7:0]  tgt;
  logic [7:0]  step_r;
  logic [8:0]  daa_t1;
  logic [8:0]  daa_t2;
  logic        daa_lo_fix;
  logic        daa_h;
  logic        daa_c1;
  logic        daa_c;
  logic [16:0] dad_sum;
  logic [7:0]  szp_src;
  logic        szp_upd;
  flags_t      f;

  always_comb begin
    a   = cur.acc;
    b   = item.operand;
    cin = cur.flags.c;

    sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cin & (item.op == OP_ADC)};
    sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin & (item.op == OP_ADC)};
    dif9   = {1'b0, a} - {1'b0, b} - {8'd0, cin & (item.op == OP_SBB)};
    dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin & (item.op == OP_SBB)};

    case (item.op)
      OP_AND:  logic_r = a & b;
      OP_XOR:  logic_r = a ^ b;
      default: logic_r = a | b;
    endcase

    tgt    = item.target_is_acc ? a : b;
    step_r = (item.op == OP_INR) ? tgt + 8'd1 : tgt - 8'd1;

    // Low-nibble fix first; its carry joins the old carry and forces the high fix.
    daa_lo_fix = (a[3:0] > 4'd9) || cur.flags.h;
    daa_h      = daa_lo_fix && (a[3:0] > 4'd9);
    daa_t1     = daa_lo_fix ? {1'b0, a} + 9'h006 : {1'b0, a};
    daa_c1     = cur.flags.c || daa_t1[8];
    daa_t2     = ((daa_t1[7:4] > 4'd9) || daa_c1) ? daa_t1 + 9'h060 : daa_t1;
    daa_c      = daa_c1 || daa_t2[8];

    dad_sum = {1'b0, item.wide_left} + {1'b0, item.wide_right};
  end

  always_comb begin
    nxt     = cur;
    f       = cur.flags;
    value   = '0;
    szp_src = '0;
    szp_upd = 1'b0;

    case (item.op)
      OP_ADD, OP_ADC: begin
        szp_src = sum9[7:0];
        szp_upd = 1'b1;
        f.h     = sum_lo[4];
        f.c     = sum9[8];
        nxt.acc = sum9[7:0];
      end
      OP_SUB, OP_SBB, OP_CMP: begin
        szp_src = dif9[7:0];
        szp_upd = 1'b1;
        f.h     = dif_lo[4];
        f.c     = dif9[8];
        if (item.op != OP_CMP) begin
          nxt.acc = dif9[7:0];
        end
      end
      OP_AND, OP_XOR, OP_OR: begin
        szp_src = logic_r;
        szp_upd = 1'b1;
        f.h     = 1'b0;
        f.c     = 1'b0;
        nxt.acc = logic_r;
      end
      OP_INR, OP_DCR: begin
        szp_src = step_r;
        szp_upd = 1'b1;
        f.h     = (item.op == OP_INR) ? (tgt[3:0] == 4'hF) : (tgt[3:0] == 4'h0);
        value   = {8'd0, step_r};
        if (item.target_is_acc) begin
          nxt.acc = step_r;
        end
      end
      OP_DAA: begin
        szp_src = daa_t2[7:0];
        szp_upd = 1'b1;
        f.h     = daa_h;
        f.c     = daa_c;
        nxt.acc = daa_t2[7:0];
      end
      OP_RLC: begin
        f.c     = a[7];
        nxt.acc = {a[6:0], a[7]};
      end
      OP_RRC: begin
        f.c     = a[0];
        nxt.acc = {a[0], a[7:1]};
      end
      OP_RAL: begin
        f.c     = a[7];
        nxt.acc = {a[6:0], cin};
      end
      OP_RAR: begin
        f.c     = a[0];
        nxt.acc = {cin, a[7:1]};
      end
      OP_CMA:  nxt.acc = ~a;
      OP_CMC:  f.c = ~cin;
      OP_STC:  f.c = 1'b1;
      OP_DAD: begin
        f.c   = dad_sum[16];
        value = dad_sum[15:0];
      end
      OP_LOAD_A: nxt.acc = b;
      OP_LOAD_PSW: begin
        nxt.acc = item.wide_left[15:8];
        f.s     = item.wide_left[7];
        f.z     = item.wide_left[6];
        f.h     = item.wide_left[4];
        f.p     = item.wide_left[2];
        f.c     = item.wide_left[0];
      end
      default: ;
    endcase

    if (szp_upd) begin
      f.s = szp_src[7];
      f.z = (szp_src == 8'd0);
      f.p = ~^szp_src;
    end
    nxt.flags = f;
  end
endmodule

// ===== sv/alu8_out_stage.sv =====
module alu8_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_vld,
  input  alu8_pkg::arch_state_t nxt,
  input  logic [15:0]           value,
  output alu8_pkg::arch_state_t cur,
  output logic                  advance,
  alu8_out_if.source            out_ch
);
  import alu8_pkg::*;

  arch_state_t state_r;
  logic        vld_r;
  logic        vld_nxt;
  res_item_t   res_r;

  // Move a beat forward when the result slot is empty or drains this cycle.
  assign advance = item_vld && (!vld_r || out_ch.ready);

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      state_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (advance) begin
        state_r <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r.acc_out   <= nxt.acc;
      res_r.value_out <= value;
      res_r.flag_byte <= pack_flags(nxt.flags);
    end
  end

  assign cur              = state_r;
  assign out_ch.valid     = vld_r;
  assign out_ch.acc_out   = res_r.acc_out;
  assign out_ch.value_out = res_r.value_out;
  assign out_ch.flag_byte = res_r.flag_byte;
endmodule

// ===== sv/alu_8080_with_flags_core.sv =====
// Channel   Dir  Handshake       Beat contents
// in_ch     in   valid / ready   op, operand, target_is_acc, wide_left, wide_right
// out_ch    out  valid / ready   acc_out, value_out, flag_byte
//
// A beat passes the input then the result register; one beat per cycle while out_ch is ready.
// The accumulator and flags update as a beat leaves the input register, so the next beat
// sees them in the following cycle.
// Synchronous active-low reset clears both valids, the accumulator and the flags.
// A stalled output holds its beat; the input register still takes a beat while the output
// waits, then holds until the output drains.
module alu_8080_with_flags_core (
  input  logic       clk,
  input  logic       rst_n,
  alu8_in_if.sink    in_ch,
  alu8_out_if.source out_ch
);
  import alu8_pkg::*;

  logic        item_vld;
  in_item_t    item;
  logic        advance;
  arch_state_t cur;
  arch_state_t nxt;
  logic [15:0] value;

  alu8_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  alu8_exec u_exec (
    .item  (item),
    .cur   (cur),
    .nxt   (nxt),
    .value (value)
  );

  alu8_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .nxt      (nxt),
    .value    (value),
    .cur      (cur),
    .advance  (advance),
    .out_ch   (out_ch)
  );
endmodule
